@@ sv/olt_pkg.sv @@
package olt_pkg;

    // list geometry
    localparam int DEPTH = 128;
    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    // fixed field widths of the request and result
    localparam int OP_W      = 3;
    localparam int POS_W     = 8;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 8;
    localparam int FIDX_W    = 7;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // find runs through a registered two-level priority tree
    localparam int GRP_SIZE  = (DEPTH < 16) ? DEPTH : 16;
    localparam int NGRP      = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int LIDX_W    = $clog2(GRP_SIZE);
    localparam int PAD_DEPTH = NGRP * GRP_SIZE;

    localparam logic [OP_W-1:0] OP_APPEND = OP_W'(0);
    localparam logic [OP_W-1:0] OP_FRONT  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_INSERT = OP_W'(2);
    localparam logic [OP_W-1:0] OP_REMOVE = OP_W'(3);
    localparam logic [OP_W-1:0] OP_FIND   = OP_W'(4);
    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(5);

    localparam logic [STAT_W-1:0] STAT_OK     = STAT_W'(0);
    localparam logic [STAT_W-1:0] STAT_FULL   = STAT_W'(1);
    localparam logic [STAT_W-1:0] STAT_BADPOS = STAT_W'(2);
    localparam logic [STAT_W-1:0] STAT_NOKEY  = STAT_W'(3);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_PICK,
        S_HOLD
    } fsm_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              cmp;
        logic [IDX_W-1:0]  at;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  pay;
        logic [CNT_W-1:0]  count;
    } cell_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [LIDX_W-1:0] lidx;
        logic [PAY_W-1:0]  pay;
    } grp_res_t;

endpackage

@@ sv/olt_cell.sv @@
module olt_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [olt_pkg::IDX_W-1:0] idx,
    input  olt_pkg::cell_cmd_t       cmd,
    input  logic [olt_pkg::KEY_W-1:0] left_key,
    input  logic [olt_pkg::PAY_W-1:0] left_pay,
    input  logic [olt_pkg::KEY_W-1:0] right_key,
    input  logic [olt_pkg::PAY_W-1:0] right_pay,
    output logic [olt_pkg::KEY_W-1:0] key_q,
    output logic [olt_pkg::PAY_W-1:0] pay_q,
    output logic                     match
);
    import olt_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic             match_reg, match_next;
    logic             occupied;

    assign occupied = (IDX_W + 1)'(idx) < (IDX_W + 1)'(cmd.count);

    always_comb
    begin
        key_next   = key_reg;
        pay_next   = pay_reg;
        match_next = match_reg;
        if (cmd.ins)
        begin
            if (idx == cmd.at)
            begin
                key_next = cmd.key;
                pay_next = cmd.pay;
            end
            else if (idx > cmd.at)
            begin
                key_next = left_key;
                pay_next = left_pay;
            end
        end
        else if (cmd.rem && (idx >= cmd.at))
        begin
            key_next = right_key;
            pay_next = right_pay;
        end
        if (cmd.cmp)
        begin
            match_next = occupied && (key_reg == cmd.key);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign key_q = key_reg;
    assign pay_q = pay_reg;
    assign match = match_reg;

endmodule

@@ sv/olt_group.sv @@
module olt_group (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [olt_pkg::GRP_SIZE-1:0]                     match,
    input  logic [olt_pkg::GRP_SIZE-1:0][olt_pkg::PAY_W-1:0] pays,
    output olt_pkg::grp_res_t                                res
);
    import olt_pkg::*;

    grp_res_t res_reg, res_next;

    // lowest matching cell of the group wins
    always_comb
    begin
        res_next = '0;
        for (int j = GRP_SIZE - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                res_next.hit  = 1'b1;
                res_next.lidx = LIDX_W'(j);
                res_next.pay  = pays[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ sv/ordered_list_table_unit.sv @@
// ordered list table: up to DEPTH entries of key and payload, kept in a chain
// of cells that shift together from the given position on an insert or remove.
// request channel: in_valid / in_stall with opcode, position, key, payload.
// result channel: out_valid / out_stall with status, entry_count,
// found_index and found_payload; one result per request, in order.
// a request is taken when in_valid is high and in_stall is low; in_stall is
// high while a request is being worked on.
// append, front, insert, remove, clear and unknown opcodes are worked in S_EXEC
// and their result is registered from there; find goes on through S_SEARCH and
// S_PICK (compare in every cell, first match per group of cells, first group).
// a new request is taken only once the last one is done, bound by the single
// command broadcast to the cell chain and the two-level match tree.
// reset empties the list at once; entry contents need no clearing.
// when the receiver stalls, the result register holds its value; the next
// request can still be taken and worked, and then waits until the result
// register frees before the block takes another.
module ordered_list_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [olt_pkg::OP_W-1:0]      opcode,
    input  logic [olt_pkg::POS_W-1:0]     position,
    input  logic [olt_pkg::KEY_W-1:0]     key,
    input  logic [olt_pkg::PAY_W-1:0]     payload,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [olt_pkg::STAT_W-1:0]    status,
    output logic [olt_pkg::CNT_OUT_W-1:0] entry_count,
    output logic [olt_pkg::FIDX_W-1:0]    found_index,
    output logic [olt_pkg::PAY_W-1:0]     found_payload
);
    import olt_pkg::*;

    fsm_t state_reg, state_next;

    // latched request
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;

    logic [CNT_W-1:0] count_reg, count_next;

    // held result while the output register is busy
    logic [STAT_W-1:0] res_status_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [PAY_W-1:0]  res_pay_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    status_reg;
    logic [CNT_OUT_W-1:0] entry_count_reg;
    logic [FIDX_W-1:0]    found_index_reg;
    logic [PAY_W-1:0]     found_payload_reg;

    cell_cmd_t        cell_cmd;
    logic [STAT_W-1:0] ex_status;
    logic             ex_find;

    logic [KEY_W-1:0] cell_key [DEPTH];
    logic [PAY_W-1:0] cell_pay [DEPTH];
    logic [PAD_DEPTH-1:0]            match_vec;
    logic [PAD_DEPTH-1:0][PAY_W-1:0] pay_pad;
    grp_res_t                        grp_res [NGRP];

    logic             pick_hit;
    logic [IDX_W-1:0] pick_idx;
    logic [PAY_W-1:0] pick_pay;

    logic              fin, capture, out_free, load_out;
    logic [STAT_W-1:0] fin_status;
    logic [CNT_W-1:0]  fin_count;
    logic [IDX_W-1:0]  fin_idx;
    logic [PAY_W-1:0]  fin_pay;

    logic [CMP_W-1:0] pos_x, cnt_x;

    assign pos_x = CMP_W'(pos_reg);
    assign cnt_x = CMP_W'(count_reg);

    // decode the request into a chain command
    always_comb
    begin
        cell_cmd       = '0;
        cell_cmd.key   = key_reg;
        cell_cmd.pay   = pay_reg;
        cell_cmd.count = count_reg;
        ex_status      = STAT_OK;
        ex_find        = 1'b0;
        count_next     = count_reg;
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                OP_APPEND, OP_FRONT, OP_INSERT:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        ex_status = STAT_FULL;
                    end
                    else if ((op_reg == OP_INSERT) && (pos_x > cnt_x))
                    begin
                        ex_status = STAT_BADPOS;
                    end
                    else
                    begin
                        cell_cmd.ins = 1'b1;
                        if (op_reg == OP_APPEND)
                        begin
                            cell_cmd.at = count_reg[IDX_W-1:0];
                        end
                        else if (op_reg == OP_FRONT)
                        begin
                            cell_cmd.at = '0;
                        end
                        else
                        begin
                            cell_cmd.at = IDX_W'(pos_reg);
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE:
                begin
                    if (pos_x >= cnt_x)
                    begin
                        ex_status = STAT_BADPOS;
                    end
                    else
                    begin
                        cell_cmd.rem = 1'b1;
                        cell_cmd.at  = IDX_W'(pos_reg);
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                OP_FIND:
                begin
                    cell_cmd.cmp = 1'b1;
                    ex_find      = 1'b1;
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // the cell chain
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        logic [KEY_W-1:0] lk, rk;
        logic [PAY_W-1:0] lp, rp;

        if (gi == 0)
        begin : g_first
            assign lk = '0;
            assign lp = '0;
        end
        else
        begin : g_left
            assign lk = cell_key[gi-1];
            assign lp = cell_pay[gi-1];
        end

        if (gi == DEPTH - 1)
        begin : g_last
            assign rk = '0;
            assign rp = '0;
        end
        else
        begin : g_right
            assign rk = cell_key[gi+1];
            assign rp = cell_pay[gi+1];
        end

        olt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(gi)),
            .cmd       (cell_cmd),
            .left_key  (lk),
            .left_pay  (lp),
            .right_key (rk),
            .right_pay (rp),
            .key_q     (cell_key[gi]),
            .pay_q     (cell_pay[gi]),
            .match     (match_vec[gi])
        );

        assign pay_pad[gi] = cell_pay[gi];
    end

    for (genvar gp = DEPTH; gp < PAD_DEPTH; gp++)
    begin : g_pad
        assign match_vec[gp] = 1'b0;
        assign pay_pad[gp]   = '0;
    end

    for (genvar gg = 0; gg < NGRP; gg++)
    begin : g_grp
        olt_group u_grp (
            .clk   (clk),
            .rst_n (rst_n),
            .match (match_vec[gg*GRP_SIZE +: GRP_SIZE]),
            .pays  (pay_pad[gg*GRP_SIZE +: GRP_SIZE]),
            .res   (grp_res[gg])
        );
    end

    // first group with a hit
    always_comb
    begin
        pick_hit = 1'b0;
        pick_idx = '0;
        pick_pay = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_res[g].hit)
            begin
                pick_hit = 1'b1;
                pick_idx = IDX_W'(g * GRP_SIZE) + IDX_W'(grp_res[g].lidx);
                pick_pay = grp_res[g].pay;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ex_find)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    state_next = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_SEARCH:
            begin
                state_next = S_PICK;
            end
            S_PICK, S_HOLD:
            begin
                state_next = out_free ? S_IDLE : S_HOLD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        in_stall   = 1'b1;
        fin        = 1'b0;
        capture    = 1'b0;
        fin_status = res_status_reg;
        fin_count  = res_count_reg;
        fin_idx    = res_idx_reg;
        fin_pay    = res_pay_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
            end
            S_EXEC:
            begin
                fin        = !ex_find;
                capture    = !ex_find;
                fin_status = ex_status;
                fin_count  = count_next;
                fin_idx    = '0;
                fin_pay    = '0;
            end
            S_PICK:
            begin
                fin        = 1'b1;
                capture    = 1'b1;
                fin_status = pick_hit ? STAT_OK : STAT_NOKEY;
                fin_count  = count_reg;
                fin_idx    = pick_idx;
                fin_pay    = pick_pay;
            end
            S_HOLD:
            begin
                fin = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign load_out       = fin && out_free;
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            key_reg <= key;
            pay_reg <= payload;
        end
        if (capture)
        begin
            res_status_reg <= fin_status;
            res_count_reg  <= fin_count;
            res_idx_reg    <= fin_idx;
            res_pay_reg    <= fin_pay;
        end
        if (load_out)
        begin
            status_reg        <= fin_status;
            entry_count_reg   <= CNT_OUT_W'(fin_count);
            found_index_reg   <= FIDX_W'(fin_idx);
            found_payload_reg <= fin_pay;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign found_index   = found_index_reg;
    assign found_payload = found_payload_reg;

endmodule

@@ sv/olt_checker.sv @@
module olt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [olt_pkg::STAT_W-1:0]    status,
    input logic [olt_pkg::CNT_OUT_W-1:0] entry_count,
    input logic [olt_pkg::FIDX_W-1:0]    found_index,
    input logic [olt_pkg::PAY_W-1:0]     found_payload
);
    import olt_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(found_index) && $stable(found_payload))
    else $error("result changed while stalled");

    // one request at a time in the chain
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in work");

    // found fields are zero on a failed request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_OK) |-> (found_index == '0) && (found_payload == '0))
    else $error("found fields set on a failed request");

    // a full status only comes with a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_FULL) |-> entry_count == CNT_OUT_W'(DEPTH))
    else $error("full status with room left");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_OUT_W'(DEPTH))
    else $error("entry count beyond depth");

endmodule

bind ordered_list_table_unit olt_checker u_olt_checker (.*);

@@ test/tb_ordered_list_table_unit.sv @@
`timescale 1ns / 1ps

module tb_ordered_list_table_unit;
    import olt_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int IDLE_PCT     = 31;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 3000;
    localparam int HOLD_AT_A    = 600;
    localparam int HOLD_AT_B    = 3400;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 1400;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } table_req_t;

    typedef struct {
        logic [STAT_W-1:0]    status;
        logic [CNT_OUT_W-1:0] count;
        logic [FIDX_W-1:0]    fidx;
        logic [PAY_W-1:0]     fpay;
    } table_rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode = '0;
    logic [POS_W-1:0]     position = '0;
    logic [KEY_W-1:0]     key = '0;
    logic [PAY_W-1:0]     payload = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [FIDX_W-1:0]    found_index;
    logic [PAY_W-1:0]     found_payload;

    ordered_list_table_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .position     (position),
        .key          (key),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_count  (entry_count),
        .found_index  (found_index),
        .found_payload(found_payload)
    );

    always #1 clk = ~clk;

    // table shadow used for prediction
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    logic [PAY_W-1:0] shadow_pays [DEPTH];
    int               shadow_len = 0;

    table_req_t req_queue[$];
    table_rsp_t pending_results[$];
    table_req_t cur_req;

    // generator side: only tracks the entry count to steer positions
    int          gen_len = 0;
    int          req_total = 0;
    logic [KEY_W-1:0] key_pool [16];

    int cyc = 0;
    int mismatches = 0;
    int hold_left = 0;

    function automatic table_rsp_t apply_table_op(table_req_t r);
        table_rsp_t rsp;
        int         at;
        int         i;
        rsp.status = STAT_OK;
        rsp.fidx = '0;
        rsp.fpay = '0;
        at = -1;
        case (r.op)
            OP_APPEND, OP_FRONT, OP_INSERT:
            begin
                if (shadow_len >= DEPTH)
                begin
                    rsp.status = STAT_FULL;
                end
                else if (r.op == OP_APPEND)
                begin
                    at = shadow_len;
                end
                else if (r.op == OP_FRONT)
                begin
                    at = 0;
                end
                else if (int'(r.pos) > shadow_len)
                begin
                    rsp.status = STAT_BADPOS;
                end
                else
                begin
                    at = int'(r.pos);
                end
                if (at >= 0)
                begin
                    for (i = shadow_len; i > at; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_pays[i] = shadow_pays[i-1];
                    end
                    shadow_keys[at] = r.key;
                    shadow_pays[at] = r.pay;
                    shadow_len++;
                end
            end
            OP_REMOVE:
            begin
                if (int'(r.pos) >= shadow_len)
                begin
                    rsp.status = STAT_BADPOS;
                end
                else
                begin
                    for (i = int'(r.pos); i + 1 < shadow_len; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_pays[i] = shadow_pays[i+1];
                    end
                    shadow_len--;
                end
            end
            OP_FIND:
            begin
                rsp.status = STAT_NOKEY;
                for (i = 0; i < shadow_len; i++)
                begin
                    if (rsp.status == STAT_NOKEY && shadow_keys[i] == r.key)
                    begin
                        rsp.status = STAT_OK;
                        rsp.fidx = FIDX_W'(i);
                        rsp.fpay = shadow_pays[i];
                    end
                end
            end
            OP_CLEAR:
            begin
                shadow_len = 0;
            end
            default:
            begin
            end
        endcase
        rsp.count = CNT_OUT_W'(shadow_len);
        return rsp;
    endfunction

    task automatic push_req(logic [OP_W-1:0] op, int pos, logic [KEY_W-1:0] k,
                            logic [PAY_W-1:0] p);
        table_req_t r;
        r.op = op;
        r.pos = POS_W'(pos);
        r.key = k;
        r.pay = p;
        req_queue.push_back(r);
        req_total++;
        case (op)
            OP_APPEND, OP_FRONT:
            begin
                if (gen_len < DEPTH) gen_len++;
            end
            OP_INSERT:
            begin
                if (gen_len < DEPTH && pos <= gen_len) gen_len++;
            end
            OP_REMOVE:
            begin
                if (pos < gen_len) gen_len--;
            end
            OP_CLEAR:
            begin
                gen_len = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    // keys mostly come from a small pool so that finds hit and duplicates occur
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 75) return key_pool[$urandom_range(15)];
        return $urandom();
    endfunction

    function automatic int insert_pos();
        if ($urandom_range(99) < 75) return $urandom_range(gen_len);
        return $urandom_range(255);
    endfunction

    function automatic int remove_pos();
        if (gen_len > 0 && $urandom_range(99) < 75) return $urandom_range(gen_len - 1);
        return $urandom_range(255);
    endfunction

    task automatic push_insert_kind(int pos);
        int r;
        r = $urandom_range(2);
        if (r == 0) push_req(OP_APPEND, $urandom_range(255), pick_key(), $urandom());
        else if (r == 1) push_req(OP_FRONT, $urandom_range(255), pick_key(), $urandom());
        else push_req(OP_INSERT, pos, pick_key(), $urandom());
    endtask

    task automatic push_mixed();
        int r;
        r = $urandom_range(99);
        if (r < 20) push_req(OP_APPEND, $urandom_range(255), pick_key(), $urandom());
        else if (r < 35) push_req(OP_FRONT, $urandom_range(255), pick_key(), $urandom());
        else if (r < 55) push_req(OP_INSERT, insert_pos(), pick_key(), $urandom());
        else if (r < 75) push_req(OP_REMOVE, remove_pos(), $urandom(), $urandom());
        else if (r < 95) push_req(OP_FIND, $urandom_range(255), pick_key(), $urandom());
        else if (r < 97) push_req(OP_CLEAR, $urandom_range(255), $urandom(), $urandom());
        else push_req(OP_W'($urandom_range(6, 7)), $urandom_range(255), $urandom(),
                      $urandom());
    endtask

    task automatic build_stimulus();
        int mode;
        int n;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < 16; n++) key_pool[n] = $urandom();

        // directed: empty list cases, both ends of the fields, every opcode
        push_req(OP_REMOVE, 0, 32'h0, 32'h0);
        push_req(OP_FIND, 0, 32'h0, 32'h0);
        push_req(OP_INSERT, 1, 32'h0, 32'h0);
        push_req(OP_INSERT, 0, 32'h0000_0000, 32'hFFFF_FFFF);
        push_req(OP_APPEND, 0, 32'hFFFF_FFFF, 32'h0000_0000);
        push_req(OP_FRONT, 255, 32'h0000_0001, 32'h1234_5678);
        push_req(OP_INSERT, 3, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_req(OP_INSERT, 5, 32'h1111_1111, 32'h2222_2222);
        push_req(OP_INSERT, 255, 32'h3333_3333, 32'h4444_4444);
        push_req(OP_FIND, 0, 32'hFFFF_FFFF, 32'h0);
        push_req(OP_FIND, 0, 32'h0000_0000, 32'h0);
        push_req(OP_FIND, 0, 32'hDEAD_BEEF, 32'h0);
        push_req(OP_APPEND, 0, 32'h0000_0000, 32'hCAFE_F00D);
        push_req(OP_FIND, 0, 32'h0000_0000, 32'h0);
        push_req(OP_W'(6), 170, 32'h5555_5555, 32'hAAAA_AAAA);
        push_req(OP_W'(7), 85, 32'hAAAA_AAAA, 32'h5555_5555);
        push_req(OP_REMOVE, 4, 32'h0, 32'h0);
        push_req(OP_REMOVE, 4, 32'h0, 32'h0);
        push_req(OP_REMOVE, 0, 32'h0, 32'h0);
        push_req(OP_REMOVE, 128, 32'h0, 32'h0);
        push_req(OP_CLEAR, 0, 32'h0, 32'h0);
        push_req(OP_FIND, 0, 32'h0, 32'h0);
        push_req(OP_CLEAR, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        while (req_total < ITEM_TARGET)
        begin
            mode = $urandom_range(9);
            if (mode < 3)
            begin
                // fill to the top, then hit the full list with inserts of random kind
                while (gen_len < DEPTH)
                begin
                    if ($urandom_range(99) < 15)
                        push_req(OP_FIND, $urandom_range(255), pick_key(), $urandom());
                    else
                        push_insert_kind($urandom_range(gen_len));
                end
                for (n = 0; n < 5; n++) push_insert_kind($urandom_range(255));
                push_req(OP_FIND, 0, pick_key(), $urandom());
            end
            else if (mode < 5)
            begin
                while (gen_len > 0)
                begin
                    n = $urandom_range(99);
                    if (n < 15)
                        push_req(OP_FIND, $urandom_range(255), pick_key(), $urandom());
                    else if (n < 20)
                        push_req(OP_REMOVE, $urandom_range(gen_len, 255), $urandom(),
                                 $urandom());
                    else
                        push_req(OP_REMOVE, $urandom_range(gen_len - 1), $urandom(),
                                 $urandom());
                end
                push_req(OP_REMOVE, $urandom_range(255), $urandom(), $urandom());
                push_req(OP_FIND, $urandom_range(255), pick_key(), $urandom());
            end
            else if (mode < 9)
            begin
                for (n = 0; n < 40; n++) push_mixed();
            end
            else
            begin
                push_req(OP_W'($urandom_range(6, 7)), $urandom_range(255), $urandom(),
                         $urandom());
                if ($urandom_range(1)) push_req(OP_CLEAR, $urandom_range(255), $urandom(),
                                                $urandom());
            end
        end
    endtask

    function automatic bit calm_now();
        return cyc >= CALM_FROM && cyc < CALM_TO;
    endfunction

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
            begin
                pending_results.push_back(apply_table_op(cur_req));
            end
            if (req_queue.size() > 0 && (calm_now() || $urandom_range(99) >= IDLE_PCT))
            begin
                cur_req = req_queue.pop_front();
                in_valid <= 1'b1;
                opcode <= cur_req.op;
                position <= cur_req.pos;
                key <= cur_req.key;
                payload <= cur_req.pay;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long back-pressure so the block fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (cyc == HOLD_AT_A || cyc == HOLD_AT_B)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        table_rsp_t exp_rsp;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d count %0d",
                           status, entry_count);
                    mismatches++;
                end
                else
                begin
                    exp_rsp = pending_results.pop_front();
                    if (status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, status);
                        mismatches++;
                    end
                    if (entry_count !== exp_rsp.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp_rsp.count,
                               entry_count);
                        mismatches++;
                    end
                    if (found_index !== exp_rsp.fidx)
                    begin
                        $error("found_index: expected %0d, got %0d", exp_rsp.fidx,
                               found_index);
                        mismatches++;
                    end
                    if (found_payload !== exp_rsp.fpay)
                    begin
                        $error("found_payload: expected %h, got %h", exp_rsp.fpay,
                               found_payload);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm_now() && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait (req_queue.size() == 0 && !in_valid);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/olt_pkg.sv
sv/olt_cell.sv
sv/olt_group.sv
sv/ordered_list_table_unit.sv
sv/olt_checker.sv
test/tb_ordered_list_table_unit.sv
